// ===== hw/rtl/mpr_pkg.sv =====
// Package for the MII PHY management register model.
// Holds the input item type, register addresses and reset constants.
// No dependencies.
package mpr_pkg;

  typedef struct packed {
    logic        link_up;
    logic [15:0] write_data;
    logic [9:0]  phy_reg;
    logic        op_read;
    logic        kind;
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);

  localparam logic KindAccess = 1'b0;
  localparam logic KindLink   = 1'b1;

  localparam logic [4:0] RegControl   = 5'd0;
  localparam logic [4:0] RegStatus    = 5'd1;
  localparam logic [4:0] RegId1       = 5'd2;
  localparam logic [4:0] RegId2       = 5'd3;
  localparam logic [4:0] RegAdvertise = 5'd4;
  localparam logic [4:0] RegPartner   = 5'd5;
  localparam logic [4:0] RegExpansion = 5'd6;
  localparam logic [4:0] RegIrqSource = 5'd29;
  localparam logic [4:0] RegIrqMask   = 5'd30;

  localparam logic [15:0] StatusBase    = 16'h7809;
  localparam logic [15:0] ControlBase   = 16'h3000;
  localparam logic [15:0] AdvertiseBase = 16'h01e1;
  localparam logic [15:0] Id1Value      = 16'h0007;
  localparam logic [15:0] Id2Value      = 16'hc0d1;
  localparam logic [15:0] PartnerValue  = 16'h0f71;
  localparam logic [15:0] ExpansionVal  = 16'h0001;
  localparam logic [15:0] ControlMask   = 16'h7980;
  localparam logic [15:0] AdvertiseMask = 16'h2d7f;
  localparam logic [15:0] AdvertiseSet  = 16'h0080;
  localparam logic [15:0] LinkBits      = 16'h0024;
  localparam logic [15:0] AnDoneBit     = 16'h0020;
  localparam logic [15:0] AnEnableBit   = 16'h1000;
  localparam logic [15:0] SoftResetBit  = 16'h8000;

  localparam logic [7:0] IrqEnergyOn = 8'h80;
  localparam logic [7:0] IrqAnDone   = 8'h40;
  localparam logic [7:0] IrqLinkDown = 8'h10;

endpackage

// ===== hw/rtl/mpr_in_reg.sv =====
// Input register stage of the MII PHY register model.
// Captures one item per transfer; depends on mpr_pkg.
module mpr_in_reg
  import mpr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  advance_i,
  output item_t item_o
);

  logic  valid_d, valid_q;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/mpr_regs.sv =====
// Management register state and access logic of the MII PHY model.
// Updates the registers and forms read data for one item; depends on mpr_pkg.
module mpr_regs
  import mpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  item_t       item_i,
  output logic [15:0] read_data_o
);

  logic [15:0] control_d, control_q;
  logic [15:0] status_d, status_q;
  logic [15:0] advertise_d, advertise_q;
  logic [7:0]  irq_src_d, irq_src_q;
  logic [7:0]  irq_mask_d, irq_mask_q;
  logic        link_d, link_q;
  logic        addr_ok;
  logic [4:0]  reg_addr;

  assign addr_ok  = (item_i.phy_reg[9:5] == 5'd0);
  assign reg_addr = item_i.phy_reg[4:0];

  always_comb begin
    control_d   = control_q;
    status_d    = status_q;
    advertise_d = advertise_q;
    irq_src_d   = irq_src_q;
    irq_mask_d  = irq_mask_q;
    link_d      = link_q;
    read_data_o = 16'h0000;
    if (item_i.kind == KindLink) begin
      link_d = item_i.link_up;
      if (item_i.link_up) begin
        status_d  = status_q | LinkBits;
        irq_src_d = irq_src_q | IrqEnergyOn | IrqAnDone;
      end else begin
        status_d  = status_q & ~LinkBits;
        irq_src_d = irq_src_q | IrqLinkDown;
      end
    end else if (addr_ok && item_i.op_read) begin
      case (reg_addr)
        RegControl:   read_data_o = control_q;
        RegStatus:    read_data_o = status_q;
        RegId1:       read_data_o = Id1Value;
        RegId2:       read_data_o = Id2Value;
        RegAdvertise: read_data_o = advertise_q;
        RegPartner:   read_data_o = PartnerValue;
        RegExpansion: read_data_o = ExpansionVal;
        RegIrqSource: begin
          read_data_o = {8'h00, irq_src_q};
          irq_src_d   = 8'h00;
        end
        RegIrqMask:   read_data_o = {8'h00, irq_mask_q};
        default:      read_data_o = 16'h0000;
      endcase
    end else if (addr_ok) begin
      case (reg_addr)
        RegControl: begin
          if ((item_i.write_data & SoftResetBit) != 16'h0000) begin
            control_d   = ControlBase;
            advertise_d = AdvertiseBase;
            irq_mask_d  = 8'h00;
            if (link_q) begin
              status_d  = StatusBase | LinkBits;
              irq_src_d = IrqEnergyOn | IrqAnDone;
            end else begin
              status_d  = StatusBase & ~LinkBits;
              irq_src_d = IrqLinkDown;
            end
          end else begin
            control_d = item_i.write_data & ControlMask;
            if ((item_i.write_data & AnEnableBit) != 16'h0000) begin
              status_d = status_q | AnDoneBit;
            end
          end
        end
        RegAdvertise: advertise_d = (item_i.write_data & AdvertiseMask) | AdvertiseSet;
        RegIrqMask:   irq_mask_d = item_i.write_data[7:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q   <= ControlBase;
      status_q    <= StatusBase | LinkBits;
      advertise_q <= AdvertiseBase;
      irq_src_q   <= IrqEnergyOn | IrqAnDone;
      irq_mask_q  <= 8'h00;
      link_q      <= 1'b1;
    end else if (fire_i) begin
      control_q   <= control_d;
      status_q    <= status_d;
      advertise_q <= advertise_d;
      irq_src_q   <= irq_src_d;
      irq_mask_q  <= irq_mask_d;
      link_q      <= link_d;
    end
  end

endmodule

// ===== hw/rtl/mpr_out_reg.sv =====
// Result register stage of the MII PHY register model.
// Holds one result until the downstream transfer; no package dependency.
module mpr_out_reg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] data_o
);

  logic        valid_d, valid_q;
  logic [15:0] data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/mii_phy_register_model_unit.sv =====
// Top level of the MII PHY management register model.
// A result is offered after its item passes the input register and then the result register.
// Throughput is one item per cycle while the result output is not stalled, since the ready
// path lets both registers advance together.
// Reset returns all management registers to their power-on values with the link up.
// Depends on mpr_pkg, mpr_in_reg, mpr_regs and mpr_out_reg.
module mii_phy_register_model_unit
  import mpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: op_read [0], phy_reg [10:1], write_data [26:11], link_up [27], zero [31:28]
  input  logic [31:0] s_axis_tdata_i,
  // tuser: kind [0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: read_data [15:0]
  output logic [15:0] m_axis_tdata_o
);

  item_t       in_item;
  item_t       cur_item;
  logic        cur_valid;
  logic        out_ready;
  logic        fire;
  logic [15:0] read_data;

  assign in_item.kind       = s_axis_tuser_i;
  assign in_item.op_read    = s_axis_tdata_i[0];
  assign in_item.phy_reg    = s_axis_tdata_i[10:1];
  assign in_item.write_data = s_axis_tdata_i[26:11];
  assign in_item.link_up    = s_axis_tdata_i[27];

  assign fire = cur_valid && out_ready;

  mpr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (cur_valid),
    .advance_i (out_ready),
    .item_o    (cur_item)
  );

  mpr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (cur_item),
    .read_data_o (read_data)
  );

  mpr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cur_valid),
    .ready_o (out_ready),
    .data_i  (read_data),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

endmodule

// ===== dv/mii_phy_register_model_unit_tb.sv =====
// Testbench for mii_phy_register_model_unit: drives management accesses and link events
// and checks every read_data transfer against a register predictor kept in the bench.
// Depends on mpr_pkg and the mii_phy_register_model_unit RTL.
module mii_phy_register_model_unit_tb;
  import mpr_pkg::*;

  typedef struct {
    item_t       item;
    int unsigned gap;
    bit          drain;
  } phy_stim_t;

  localparam logic [4:0] RegUnmapped = 5'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  mii_phy_register_model_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  phy_stim_t   phy_stim_q[$];
  logic [15:0] read_data_q[$];
  int unsigned mismatch_cnt = 0;
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_cnt = 0;
  item_t       tx_cur;

  // Predicted PHY register state.
  logic [15:0] ctrl_m;
  logic [15:0] status_m;
  logic [15:0] adv_m;
  logic [7:0]  irq_src_m;
  logic [7:0]  irq_mask_m;
  logic        link_m;

  function automatic void apply_link_state();
    if (link_m) begin
      status_m  = status_m | LinkBits;
      irq_src_m = irq_src_m | IrqEnergyOn | IrqAnDone;
    end else begin
      status_m  = status_m & ~LinkBits;
      irq_src_m = irq_src_m | IrqLinkDown;
    end
  endfunction

  function automatic void phy_soft_reset();
    status_m   = StatusBase;
    ctrl_m     = ControlBase;
    adv_m      = AdvertiseBase;
    irq_mask_m = '0;
    irq_src_m  = '0;
    apply_link_state();
  endfunction

  function automatic logic [15:0] phy_predict_result(item_t it);
    logic [15:0] rd;
    rd = '0;
    if (it.kind == KindLink) begin
      link_m = it.link_up;
      apply_link_state();
    end else if (it.phy_reg[9:5] == 5'd0) begin
      if (it.op_read) begin
        case (it.phy_reg[4:0])
          RegControl:   rd = ctrl_m;
          RegStatus:    rd = status_m;
          RegId1:       rd = Id1Value;
          RegId2:       rd = Id2Value;
          RegAdvertise: rd = adv_m;
          RegPartner:   rd = PartnerValue;
          RegExpansion: rd = ExpansionVal;
          RegIrqSource: begin
            rd        = {8'h00, irq_src_m};
            irq_src_m = '0;
          end
          RegIrqMask:   rd = {8'h00, irq_mask_m};
          default:      rd = '0;
        endcase
      end else begin
        case (it.phy_reg[4:0])
          RegControl: begin
            if ((it.write_data & SoftResetBit) != '0) begin
              phy_soft_reset();
            end else begin
              ctrl_m = it.write_data & ControlMask;
              if ((it.write_data & AnEnableBit) != '0) status_m = status_m | AnDoneBit;
            end
          end
          RegAdvertise: adv_m = (it.write_data & AdvertiseMask) | AdvertiseSet;
          RegIrqMask:   irq_mask_m = it.write_data[7:0];
          default: ;
        endcase
      end
    end
    return rd;
  endfunction

  task automatic add_item(item_t it, bit drain);
    phy_stim_t s;
    s.item  = it;
    s.gap   = tx_fast ? 0 : $urandom_range(0, 7);
    s.drain = drain;
    phy_stim_q.push_back(s);
  endtask

  task automatic add_access(bit rd, logic [9:0] addr, logic [15:0] wd);
    item_t it;
    it.kind       = KindAccess;
    it.op_read    = rd;
    it.phy_reg    = addr;
    it.write_data = wd;
    it.link_up    = 1'($urandom_range(0, 1));
    add_item(it, 1'b0);
  endtask

  task automatic add_link(bit up);
    item_t it;
    it.kind       = KindLink;
    it.op_read    = 1'($urandom_range(0, 1));
    it.phy_reg    = 10'($urandom_range(0, 1023));
    it.write_data = 16'($urandom_range(0, 65535));
    it.link_up    = up;
    add_item(it, 1'b0);
  endtask

  initial begin
    logic [4:0] mapped[9];
    int unsigned sel;
    logic [15:0] wd;
    link_m = 1'b1;
    phy_soft_reset();
    mapped = '{RegControl, RegStatus, RegId1, RegId2, RegAdvertise, RegPartner,
               RegExpansion, RegIrqSource, RegIrqMask};

    // Directed part: reset values, masked writes, ignored addresses above 31, link events and a soft reset.
    tx_fast = 1'b1;
    for (int i = 0; i < 9; i++) add_access(1'b1, {5'd0, mapped[i]}, 16'hffff);
    add_access(1'b1, {5'd0, RegIrqSource}, 16'h0000);
    add_access(1'b1, {5'd0, RegUnmapped}, 16'h0000);
    add_access(1'b0, 10'd32, 16'h8000);
    add_access(1'b0, 10'h3e0, 16'h0000);
    add_access(1'b1, 10'h3ff, 16'hffff);
    add_access(1'b0, {5'd0, RegControl}, 16'h7fff);
    add_access(1'b0, {5'd0, RegAdvertise}, 16'hffff);
    add_access(1'b0, {5'd0, RegIrqMask}, 16'hffff);
    add_access(1'b0, {5'd0, RegUnmapped}, 16'hffff);
    add_link(1'b0);
    add_link(1'b0);
    add_access(1'b1, {5'd0, RegStatus}, 16'h0000);
    add_access(1'b1, {5'd0, RegIrqSource}, 16'h0000);
    add_link(1'b1);
    add_access(1'b0, {5'd0, RegControl}, 16'h8000);
    add_access(1'b1, {5'd0, RegIrqSource}, 16'h0000);

    for (int i = 0; i < 650; i++) begin
      if (i % 50 == 0) tx_fast = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        add_link(1'($urandom_range(0, 1)));
      end else if (sel < 20) begin
        add_access(1'($urandom_range(0, 1)), 10'($urandom_range(32, 1023)),
                   16'($urandom_range(0, 65535)));
      end else if (sel < 30) begin
        wd = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) != 0) wd = wd & ~SoftResetBit;
        add_access(1'b0, {5'd0, RegControl}, wd);
      end else if (sel < 80) begin
        add_access($urandom_range(0, 2) != 0, {5'd0, mapped[$urandom_range(0, 8)]},
                   16'($urandom_range(0, 65535)));
      end else begin
        add_access($urandom_range(0, 2) != 0, 10'($urandom_range(0, 31)),
                   16'($urandom_range(0, 65535)));
      end
      if (i == 0 || i == 300) phy_stim_q[$].drain = 1'b1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) read_data_q.push_back(phy_predict_result(tx_cur));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid_i <= 1'b0;
        end else if (phy_stim_q.size() != 0 &&
                     !(phy_stim_q[0].drain && read_data_q.size() != 0)) begin
          tx_cur  = phy_stim_q[0].item;
          tx_wait = phy_stim_q[0].gap;
          phy_stim_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {4'b0000, tx_cur.link_up, tx_cur.write_data, tx_cur.phy_reg,
                              tx_cur.op_read};
          s_axis_tuser_i  <= tx_cur.kind;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] exp_data;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (read_data_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("Unexpected result transfer: read_data %h",
                                           m_axis_tdata_o);
        end else begin
          exp_data = read_data_q.pop_front();
          if (m_axis_tdata_o !== exp_data) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("read_data mismatch: expected %h, got %h",
                                             exp_data, m_axis_tdata_o);
          end
        end
        rx_cnt++;
        if (rx_cnt % 64 == 0) rx_fast = ($urandom_range(0, 2) == 0);
        rx_stall = rx_fast ? 0 : $urandom_range(0, 7);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      m_axis_tready_i <= (rx_stall == 0);
    end
  end

  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    while (phy_stim_q.size() != 0 || s_axis_tvalid_i || read_data_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && read_data_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
